// ===== rtl/core/sst_pkg.sv =====
package sst_pkg;

    localparam int SST_QUEUE_DEPTH = 4;

    localparam logic [1:0] PH_START   = 2'd0;
    localparam logic [1:0] PH_NAME    = 2'd1;
    localparam logic [1:0] PH_VALUE   = 2'd2;
    localparam logic [1:0] PH_COMMENT = 2'd3;

    localparam logic [1:0] FK_UNKNOWN = 2'd0;
    localparam logic [1:0] FK_EVENT   = 2'd1;
    localparam logic [1:0] FK_DATA    = 2'd2;
    localparam logic [1:0] FK_OTHER   = 2'd3;

    localparam logic [1:0] K_DATA    = 2'd0;
    localparam logic [1:0] K_NAME    = 2'd1;
    localparam logic [1:0] K_RESTART = 2'd2;
    localparam logic [1:0] K_DONE    = 2'd3;

    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;

    localparam logic [2:0] EVENT_LEN = 3'd5;
    localparam logic [2:0] DATA_LEN  = 3'd4;

    typedef struct packed {
        logic       func;
        logic [7:0] byte_value;
    } t_in_item;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] out_byte;
        logic       last;
    } t_out_item;

    typedef struct packed {
        logic [1:0] phase;
        logic [2:0] match_pos;
        logic [1:0] field_kind;
        logic       held_cr;
        logic       space_checked;
        logic       data_nonempty;
        logic       event_pending;
    } t_state;

    localparam t_state STATE_RESET = '{
        phase:         PH_START,
        match_pos:     3'd0,
        field_kind:    FK_UNKNOWN,
        held_cr:       1'b0,
        space_checked: 1'b0,
        data_nonempty: 1'b0,
        event_pending: 1'b0
    };

    typedef struct packed {
        logic [1:0] count;
        t_out_item  first;
        t_out_item  second;
    } t_step_res;

endpackage

// ===== rtl/core/sse_stream_tokenizer_core.sv =====
// channel   direction  handshake           payload
// item      in         i_valid / o_stall   i_item   (func, byte_value)
// result    out        o_valid / i_stall   o_result (kind, out_byte, last)
//
// one item per cycle while the queue has room, up to two results per item; items wait
// in the input register, results in the queue, which takes up to two entries per item
// and gives one per cycle unless stalled, so items with two results slow the input
// synchronous active-low reset returns the parser to line start with no event pending
// o_stall rises only while the result queue has fewer than two free entries
module sse_stream_tokenizer_core #(
    parameter int QUEUE_DEPTH = sst_pkg::SST_QUEUE_DEPTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  sst_pkg::t_in_item  i_item,
    output logic               o_valid,
    input  logic               i_stall,
    output sst_pkg::t_out_item o_result
);

    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    logic               r_in_valid;
    sst_pkg::t_in_item  r_in;
    sst_pkg::t_state    r_state;
    sst_pkg::t_state    n_state;
    sst_pkg::t_step_res step_res;
    logic               room;
    logic               advance;
    logic               accept;
    logic [CW-1:0]      level;

    assign advance = r_in_valid && room;
    assign o_stall = r_in_valid && !room;
    assign accept  = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_state    <= sst_pkg::STATE_RESET;
        end else begin
            if (accept) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_state <= n_state;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in <= i_item;
        end
    end

    sst_step u_step (
        .i_state (r_state),
        .i_item  (r_in),
        .o_state (n_state),
        .o_res   (step_res)
    );

    sst_res_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push_en (advance),
        .i_push    (step_res),
        .o_room    (room),
        .o_level   (level),
        .o_valid   (o_valid),
        .o_item    (o_result),
        .i_stall   (i_stall)
    );

    a_level_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        level <= CW'(QUEUE_DEPTH))
        else $error("result queue overfilled");

    a_eos_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && r_in.func |=> r_state == sst_pkg::STATE_RESET)
        else $error("end of stream left parser state behind");

    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !room |=> r_in_valid && $stable(r_in) && $stable(r_state))
        else $error("held item or state changed while blocked");

endmodule

// ===== rtl/core/sst_step.sv =====
module sst_step (
    input  sst_pkg::t_state    i_state,
    input  sst_pkg::t_in_item  i_item,
    output sst_pkg::t_state    o_state,
    output sst_pkg::t_step_res o_res
);

    typedef struct packed {
        logic          emit;
        logic [1:0]    kind;
        logic [7:0]    out_byte;
        sst_pkg::t_state st;
    } t_part;

    function automatic t_part no_emit(sst_pkg::t_state s);
        t_part p;
        p.emit     = 1'b0;
        p.kind     = sst_pkg::K_DATA;
        p.out_byte = 8'h00;
        p.st       = s;
        return p;
    endfunction

    function automatic logic [7:0] event_char(logic [2:0] pos);
        logic [7:0] ch;
        case (pos)
            3'd0:    ch = 8'h65;
            3'd1:    ch = 8'h76;
            3'd2:    ch = 8'h65;
            3'd3:    ch = 8'h6E;
            3'd4:    ch = 8'h74;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    function automatic logic [7:0] data_char(logic [2:0] pos);
        logic [7:0] ch;
        case (pos)
            3'd0:    ch = 8'h64;
            3'd1:    ch = 8'h61;
            3'd2:    ch = 8'h74;
            3'd3:    ch = 8'h61;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    function automatic sst_pkg::t_state name_byte(sst_pkg::t_state s, logic [7:0] c);
        sst_pkg::t_state r;
        r = s;
        case (s.field_kind)
            sst_pkg::FK_UNKNOWN: begin
                if (c == data_char(3'd0) - 8'h00 && c == 8'h64) begin
                    r.field_kind = sst_pkg::FK_DATA;
                    r.match_pos  = 3'd1;
                end else if (c == event_char(3'd0)) begin
                    r.field_kind = sst_pkg::FK_EVENT;
                    r.match_pos  = 3'd1;
                end else begin
                    r.field_kind = sst_pkg::FK_OTHER;
                end
            end
            sst_pkg::FK_EVENT: begin
                if (s.match_pos < sst_pkg::EVENT_LEN && c == event_char(s.match_pos)) begin
                    r.match_pos = s.match_pos + 3'd1;
                end else begin
                    r.field_kind = sst_pkg::FK_OTHER;
                end
            end
            sst_pkg::FK_DATA: begin
                if (s.match_pos < sst_pkg::DATA_LEN && c == data_char(s.match_pos)) begin
                    r.match_pos = s.match_pos + 3'd1;
                end else begin
                    r.field_kind = sst_pkg::FK_OTHER;
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    function automatic t_part start_value(sst_pkg::t_state s);
        t_part      p;
        logic [1:0] k;
        p = no_emit(s);
        k = sst_pkg::FK_OTHER;
        if (s.field_kind == sst_pkg::FK_EVENT && s.match_pos == sst_pkg::EVENT_LEN) begin
            k = sst_pkg::FK_EVENT;
        end else if (s.field_kind == sst_pkg::FK_DATA && s.match_pos == sst_pkg::DATA_LEN) begin
            k = sst_pkg::FK_DATA;
        end
        p.st.field_kind = k;
        if (k == sst_pkg::FK_DATA && s.data_nonempty) begin
            p.emit     = 1'b1;
            p.kind     = sst_pkg::K_DATA;
            p.out_byte = sst_pkg::CH_LF;
        end else if (k == sst_pkg::FK_EVENT) begin
            p.emit = 1'b1;
            p.kind = sst_pkg::K_RESTART;
        end
        return p;
    endfunction

    function automatic t_part close_event(sst_pkg::t_state s);
        t_part p;
        p = no_emit(s);
        if (s.event_pending) begin
            p.emit             = 1'b1;
            p.kind             = sst_pkg::K_DONE;
            p.st.event_pending = 1'b0;
            p.st.data_nonempty = 1'b0;
        end
        return p;
    endfunction

    function automatic t_part line_byte(sst_pkg::t_state s, logic [7:0] c);
        t_part           p;
        sst_pkg::t_state t;
        p = no_emit(s);
        t = s;
        case (s.phase)
            sst_pkg::PH_START: begin
                if (c == sst_pkg::CH_COLON) begin
                    p.st.phase = sst_pkg::PH_COMMENT;
                end else begin
                    t.event_pending = 1'b1;
                    t.phase         = sst_pkg::PH_NAME;
                    p.st            = name_byte(t, c);
                end
            end
            sst_pkg::PH_NAME: begin
                if (c == sst_pkg::CH_COLON) begin
                    p                  = start_value(s);
                    p.st.phase         = sst_pkg::PH_VALUE;
                    p.st.space_checked = 1'b0;
                end else begin
                    p.st = name_byte(s, c);
                end
            end
            sst_pkg::PH_VALUE: begin
                p.st.space_checked = 1'b1;
                if (s.space_checked || c != sst_pkg::CH_SPACE) begin
                    if (s.field_kind == sst_pkg::FK_EVENT) begin
                        p.emit     = 1'b1;
                        p.kind     = sst_pkg::K_NAME;
                        p.out_byte = c;
                    end else if (s.field_kind == sst_pkg::FK_DATA) begin
                        p.emit             = 1'b1;
                        p.kind             = sst_pkg::K_DATA;
                        p.out_byte         = c;
                        p.st.data_nonempty = 1'b1;
                    end
                end
            end
            default: ;
        endcase
        return p;
    endfunction

    function automatic t_part line_end(sst_pkg::t_state s);
        t_part p;
        case (s.phase)
            sst_pkg::PH_START: p = close_event(s);
            sst_pkg::PH_NAME:  p = start_value(s);
            default:           p = no_emit(s);
        endcase
        p.st.phase         = sst_pkg::PH_START;
        p.st.match_pos     = 3'd0;
        p.st.field_kind    = sst_pkg::FK_UNKNOWN;
        p.st.space_checked = 1'b0;
        return p;
    endfunction

    t_part           part_a;
    t_part           part_b;
    sst_pkg::t_state base;
    sst_pkg::t_state n_state;

    always_comb begin
        base         = i_state;
        base.held_cr = 1'b0;
        part_a       = no_emit(base);
        part_b       = no_emit(base);
        n_state      = base;
        if (i_item.func) begin
            part_a  = line_end(base);
            part_b  = close_event(part_a.st);
            n_state = sst_pkg::STATE_RESET;
        end else if (i_item.byte_value == sst_pkg::CH_LF) begin
            part_a  = line_end(base);
            n_state = part_a.st;
        end else begin
            // a held cr not followed by lf goes through as a line byte
            if (i_state.held_cr) begin
                part_a = line_byte(base, sst_pkg::CH_CR);
            end
            if (i_item.byte_value == sst_pkg::CH_CR) begin
                n_state         = part_a.st;
                n_state.held_cr = 1'b1;
            end else begin
                part_b  = line_byte(part_a.st, i_item.byte_value);
                n_state = part_b.st;
            end
        end
    end

    always_comb begin
        o_state                = n_state;
        o_res.count            = {1'b0, part_a.emit} + {1'b0, part_b.emit};
        o_res.second.kind      = part_b.kind;
        o_res.second.out_byte  = part_b.out_byte;
        o_res.second.last      = 1'b1;
        if (part_a.emit) begin
            o_res.first.kind     = part_a.kind;
            o_res.first.out_byte = part_a.out_byte;
            o_res.first.last     = !part_b.emit;
        end else begin
            o_res.first.kind     = part_b.kind;
            o_res.first.out_byte = part_b.out_byte;
            o_res.first.last     = 1'b1;
        end
    end

endmodule

// ===== rtl/core/sst_res_queue.sv =====
module sst_res_queue #(
    parameter int DEPTH = sst_pkg::SST_QUEUE_DEPTH
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_push_en,
    input  sst_pkg::t_step_res         i_push,
    output logic                       o_room,
    output logic [$clog2(DEPTH+1)-1:0] o_level,
    output logic                       o_valid,
    output sst_pkg::t_out_item         o_item,
    input  logic                       i_stall
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    function automatic logic [PW-1:0] ptr_inc(logic [PW-1:0] p);
        return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
    endfunction

    sst_pkg::t_out_item r_mem [DEPTH];
    logic [PW-1:0]      r_wr;
    logic [PW-1:0]      r_rd;
    logic [CW-1:0]      r_count;
    logic [PW-1:0]      n_wr;
    logic [PW-1:0]      n_rd;
    logic [CW-1:0]      n_count;
    logic [1:0]         push_cnt;
    logic               pop;

    assign push_cnt = i_push_en ? i_push.count : 2'd0;
    assign o_valid  = (r_count != '0);
    assign pop      = o_valid && !i_stall;
    assign o_item   = r_mem[r_rd];
    assign o_room   = (r_count <= CW'(DEPTH - 2));
    assign o_level  = r_count;

    always_comb begin
        n_count = r_count + CW'(push_cnt) - CW'(pop);
        n_rd    = pop ? ptr_inc(r_rd) : r_rd;
        case (push_cnt)
            2'd1:    n_wr = ptr_inc(r_wr);
            2'd2:    n_wr = ptr_inc(ptr_inc(r_wr));
            default: n_wr = r_wr;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_cnt != 2'd0) begin
            r_mem[r_wr] <= i_push.first;
        end
        if (push_cnt == 2'd2) begin
            r_mem[ptr_inc(r_wr)] <= i_push.second;
        end
    end

endmodule

// ===== dv/tb.sv =====
module tb;

    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 300;
    localparam logic [39:0] WORD_EVENT = "event";
    localparam logic [31:0] WORD_DATA = "data";

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_stall;
    sst_pkg::t_in_item  i_item;
    logic               o_valid;
    logic               i_stall;
    sst_pkg::t_out_item o_result;

    sse_stream_tokenizer_core dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .i_item   (i_item),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .o_result (o_result)
    );

    always #5 i_clk = ~i_clk;

    logic [1:0] ps_phase;
    logic [2:0] ps_match;
    logic [1:0] ps_field;
    logic       ps_cr;
    logic       ps_space;
    logic       ps_data;
    logic       ps_open;

    sst_pkg::t_out_item step_buf[2];
    int                 step_cnt = 0;
    sst_pkg::t_out_item expected_results[$];

    int  errors = 0;
    int  items_sent = 0;
    int  results_seen = 0;
    int  events_closed = 0;
    int  input_stall_cycles = 0;
    int  cycle_count = 0;
    bit  idle_on = 1'b0;
    bit  hold_req = 1'b0;

    string FIELD_NAMES[10] = '{"data", "data", "data", "event", "event",
                               "id", "retry", "dat", "eventx", "d"};

    function automatic void tok_emit(logic [1:0] k, logic [7:0] b);
        sst_pkg::t_out_item r;
        if (step_cnt < 2) begin
            r.kind = k;
            r.out_byte = b;
            r.last = 1'b0;
            step_buf[step_cnt] = r;
            step_cnt++;
        end
    endfunction

    function automatic void tok_clear_line();
        ps_phase = sst_pkg::PH_START;
        ps_match = 3'd0;
        ps_field = sst_pkg::FK_UNKNOWN;
        ps_space = 1'b0;
    endfunction

    function automatic void tok_reset();
        tok_clear_line();
        ps_cr = 1'b0;
        ps_data = 1'b0;
        ps_open = 1'b0;
    endfunction

    function automatic void tok_close_event();
        if (ps_open) begin
            tok_emit(sst_pkg::K_DONE, 8'h00);
            ps_open = 1'b0;
            ps_data = 1'b0;
        end
    endfunction

    function automatic void tok_start_value();
        logic [1:0] k;
        k = sst_pkg::FK_OTHER;
        if (ps_field == sst_pkg::FK_EVENT && ps_match == sst_pkg::EVENT_LEN)
            k = sst_pkg::FK_EVENT;
        else if (ps_field == sst_pkg::FK_DATA && ps_match == sst_pkg::DATA_LEN)
            k = sst_pkg::FK_DATA;
        ps_field = k;
        if (k == sst_pkg::FK_DATA && ps_data)
            tok_emit(sst_pkg::K_DATA, sst_pkg::CH_LF);
        else if (k == sst_pkg::FK_EVENT)
            tok_emit(sst_pkg::K_RESTART, 8'h00);
    endfunction

    function automatic void tok_name_byte(logic [7:0] c);
        case (ps_field)
            sst_pkg::FK_UNKNOWN: begin
                if (c == "e") begin
                    ps_field = sst_pkg::FK_EVENT;
                    ps_match = 3'd1;
                end else if (c == "d") begin
                    ps_field = sst_pkg::FK_DATA;
                    ps_match = 3'd1;
                end else begin
                    ps_field = sst_pkg::FK_OTHER;
                end
            end
            sst_pkg::FK_EVENT: begin
                if (ps_match < sst_pkg::EVENT_LEN &&
                    c == WORD_EVENT[39 - 8 * int'(ps_match) -: 8])
                    ps_match = ps_match + 3'd1;
                else
                    ps_field = sst_pkg::FK_OTHER;
            end
            sst_pkg::FK_DATA: begin
                if (ps_match < sst_pkg::DATA_LEN &&
                    c == WORD_DATA[31 - 8 * int'(ps_match) -: 8])
                    ps_match = ps_match + 3'd1;
                else
                    ps_field = sst_pkg::FK_OTHER;
            end
            default: ;
        endcase
    endfunction

    function automatic void tok_line_end();
        if (ps_phase == sst_pkg::PH_START)
            tok_close_event();
        else if (ps_phase == sst_pkg::PH_NAME)
            tok_start_value();
        tok_clear_line();
    endfunction

    function automatic void tok_line_byte(logic [7:0] c);
        case (ps_phase)
            sst_pkg::PH_START: begin
                if (c == sst_pkg::CH_COLON) begin
                    ps_phase = sst_pkg::PH_COMMENT;
                end else begin
                    ps_open = 1'b1;
                    ps_phase = sst_pkg::PH_NAME;
                    tok_name_byte(c);
                end
            end
            sst_pkg::PH_NAME: begin
                if (c == sst_pkg::CH_COLON) begin
                    tok_start_value();
                    ps_phase = sst_pkg::PH_VALUE;
                    ps_space = 1'b0;
                end else begin
                    tok_name_byte(c);
                end
            end
            sst_pkg::PH_VALUE: begin
                if (!ps_space && c == sst_pkg::CH_SPACE) begin
                    ps_space = 1'b1;
                end else begin
                    ps_space = 1'b1;
                    if (ps_field == sst_pkg::FK_EVENT) begin
                        tok_emit(sst_pkg::K_NAME, c);
                    end else if (ps_field == sst_pkg::FK_DATA) begin
                        tok_emit(sst_pkg::K_DATA, c);
                        ps_data = 1'b1;
                    end
                end
            end
            default: ;
        endcase
    endfunction

    function automatic void predict_tokens(sst_pkg::t_in_item it);
        step_cnt = 0;
        if (it.func) begin
            ps_cr = 1'b0;
            tok_line_end();
            tok_close_event();
            tok_reset();
        end else if (it.byte_value == sst_pkg::CH_LF) begin
            ps_cr = 1'b0;
            tok_line_end();
        end else begin
            if (ps_cr) begin
                ps_cr = 1'b0;
                tok_line_byte(sst_pkg::CH_CR);
            end
            if (it.byte_value == sst_pkg::CH_CR)
                ps_cr = 1'b1;
            else
                tok_line_byte(it.byte_value);
        end
        if (step_cnt > 0)
            step_buf[step_cnt - 1].last = 1'b1;
        for (int i = 0; i < step_cnt; i++)
            expected_results.insert(expected_results.size(), step_buf[i]);
    endfunction

    task automatic send_item(input sst_pkg::t_in_item it);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_item <= it;
        @(posedge i_clk);
        while (o_stall)
            @(posedge i_clk);
        predict_tokens(it);
        items_sent++;
    endtask

    task automatic put_byte(input logic [7:0] b);
        send_item(sst_pkg::t_in_item'{func: 1'b0, byte_value: b});
    endtask

    task automatic put_eos();
        send_item(sst_pkg::t_in_item'{func: 1'b1, byte_value: 8'($urandom_range(0, 255))});
    endtask

    task automatic put_text(input string s);
        for (int i = 0; i < s.len(); i++)
            put_byte(s[i]);
    endtask

    task automatic put_value();
        int len;
        int r;
        len = $urandom_range(0, 6);
        for (int i = 0; i < len; i++) begin
            r = $urandom_range(0, 19);
            if (r == 0)
                put_byte(sst_pkg::CH_CR);
            else if (r == 1)
                put_byte(8'($urandom_range(0, 255)));
            else
                put_byte(8'($urandom_range(8'h20, 8'h7E)));
        end
    endtask

    task automatic send_random_line();
        int pick;
        int term;
        pick = $urandom_range(0, 9);
        if (pick == 1) begin
            put_byte(sst_pkg::CH_COLON);
            put_value();
        end else if (pick != 0) begin
            put_text(FIELD_NAMES[$urandom_range(0, 9)]);
            if ($urandom_range(0, 7) != 0) begin
                put_byte(sst_pkg::CH_COLON);
                if ($urandom_range(0, 1) == 1)
                    put_byte(sst_pkg::CH_SPACE);
                put_value();
            end
        end
        term = $urandom_range(0, 15);
        if (term >= 8 && term <= 14)
            put_byte(sst_pkg::CH_CR);
        if (term >= 14)
            put_eos();
        else
            put_byte(sst_pkg::CH_LF);
    endtask

    task automatic send_noise();
        int n;
        int r;
        n = $urandom_range(1, 8);
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(0, 15);
            case (r)
                0: put_eos();
                1: put_byte(sst_pkg::CH_LF);
                2: put_byte(sst_pkg::CH_CR);
                3: put_byte(sst_pkg::CH_COLON);
                4: put_byte(sst_pkg::CH_SPACE);
                default: put_byte(8'($urandom_range(0, 255)));
            endcase
        end
    endtask

    task automatic run_stream(input int count);
        int stop_at;
        stop_at = items_sent + count;
        while (items_sent < stop_at) begin
            if ($urandom_range(0, 4) == 0)
                send_noise();
            else
                send_random_line();
            if ($urandom_range(0, 3) == 0)
                put_byte(sst_pkg::CH_LF);
        end
    endtask

    task automatic test_data_values();
        put_text("data:");
        put_byte(sst_pkg::CH_LF);
        put_text("data: ");
        put_byte(8'hFF);
        put_byte(sst_pkg::CH_CR);
        put_byte(8'h00);
        put_byte(sst_pkg::CH_LF);
    endtask

    task automatic test_cr_and_other_field();
        put_byte(sst_pkg::CH_CR);
        put_byte(sst_pkg::CH_CR);
        put_byte(sst_pkg::CH_LF);
        put_byte(sst_pkg::CH_LF);
        put_text("id: 7");
        put_byte(sst_pkg::CH_LF);
        put_byte(sst_pkg::CH_LF);
    endtask

    task automatic test_event_and_eos();
        put_text("event");
        put_byte(sst_pkg::CH_CR);
        put_eos();
    endtask

    task automatic test_random_stream();
        run_stream(560);
    endtask

    task automatic test_receiver_holdoff();
        hold_req = 1'b1;
        run_stream(40);
    endtask

    task automatic test_quiet_tail();
        idle_on = 1'b0;
        run_stream(100);
    endtask

    initial begin
        i_stall = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                i_stall <= 1'b1;
                repeat (HOLD_CYCLES - 1) @(posedge i_clk);
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                i_stall <= 1'b1;
                repeat ($urandom_range(0, 3)) @(posedge i_clk);
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        sst_pkg::t_out_item want;
        if (i_rst_n && o_valid && !i_stall) begin
            results_seen++;
            if (expected_results.size() == 0) begin
                errors++;
                $display("%0t: expected no result, got kind=%0d byte=%02h last=%0b", $time,
                         o_result.kind, o_result.out_byte, o_result.last);
            end else begin
                want = expected_results.pop_front();
                if (want.kind == sst_pkg::K_DONE)
                    events_closed++;
                if (o_result.kind !== want.kind || o_result.out_byte !== want.out_byte ||
                    o_result.last !== want.last) begin
                    errors++;
                    $display("%0t: expected kind=%0d byte=%02h last=%0b, got kind=%0d byte=%02h last=%0b",
                             $time, want.kind, want.out_byte, want.last,
                             o_result.kind, o_result.out_byte, o_result.last);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (i_rst_n && i_valid && o_stall)
            input_stall_cycles++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
                     expected_results.size());
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial begin
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_item = '0;
        tok_reset();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        idle_on = 1'b1;

        test_data_values();
        test_cr_and_other_field();
        test_event_and_eos();
        test_random_stream();
        test_receiver_holdoff();
        test_quiet_tail();
        i_valid <= 1'b0;

        while (expected_results.size() > 0)
            @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        $display("sent %0d stream items, checked %0d results, %0d events closed",
                 items_sent, results_seen, events_closed);
        $display("input held back for %0d cycles under receiver pressure", input_stall_cycles);
        if (errors == 0 && expected_results.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("%0d mismatches, %0d results never seen", errors, expected_results.size());
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
